// ----- sv/lirs_pkg.sv -----
// Shared types, constants and sample format helpers for the linear interpolation resampler.
`timescale 1ns / 1ps

package lirs_pkg;

    localparam int PHASE_W   = 21;   // phase accumulator and step register width
    localparam int COUNT_W   = 4;    // channel count register width
    localparam int CH_W      = 3;    // channel index width on the ports
    localparam int SAMPLE_W  = 32;   // raw and decoded sample width
    localparam int CFG_IDX_W = 2;
    localparam int FRAMES_PER_INPUT = 8;  // output frames per input frame at minimum step

    localparam int DEF_MAX_CHANNELS = 8;
    localparam int DEF_FRAC_BITS    = 16;

    localparam logic [PHASE_W-1:0] PHASE_STEP_RESET    = 21'd65536;
    localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RESET = 4'd2;

    typedef enum logic [1:0] {
        FMT_S8  = 2'd0,
        FMT_U8  = 2'd1,
        FMT_S16 = 2'd2,
        FMT_S32 = 2'd3
    } fmt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_STEP    = 2'd0,
        REG_CHANNEL_COUNT = 2'd1,
        REG_SAMPLE_FORMAT = 2'd2
    } cfg_reg_t;

    // One decoded input sample, handed from the front to the back.
    typedef struct packed {
        logic [CH_W-1:0]            chan;
        logic signed [SAMPLE_W-1:0] value;
        logic                       frame_done;
    } job_t;

    // One result beat.
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [CH_W-1:0]     chan;
        logic                last;
    } result_t;

    // Clamp the channel count register to 1..max_ch.
    function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] cc,
                                                       input int unsigned max_ch);
        logic [COUNT_W-1:0] r;
        begin
            r = cc;
            if (cc == '0)
                r = COUNT_W'(1);
            else if (cc > COUNT_W'(max_ch))
                r = COUNT_W'(max_ch);
            return r;
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] decode_sample(input logic [SAMPLE_W-1:0] raw,
                                                                 input fmt_t fmt);
        logic signed [SAMPLE_W-1:0] r;
        begin
            unique case (fmt)
                FMT_S8:  r = {{24{raw[7]}}, raw[7:0]};
                FMT_U8:  r = {{24{~raw[7]}}, ~raw[7], raw[6:0]};
                FMT_S16: r = {{16{raw[15]}}, raw[15:0]};
                default: r = raw;
            endcase
            return r;
        end
    endfunction

    // Saturate a wide signed value to the format and pack it into raw bits.
    function automatic logic [SAMPLE_W-1:0] encode_sample(input logic signed [34:0] v,
                                                          input fmt_t fmt);
        logic signed [34:0] lo;
        logic signed [34:0] hi;
        logic signed [34:0] s;
        logic [SAMPLE_W-1:0] r;
        begin
            unique case (fmt)
                FMT_S8, FMT_U8:
                begin
                    lo = -35'sd128;
                    hi = 35'sd127;
                end
                FMT_S16:
                begin
                    lo = -35'sd32768;
                    hi = 35'sd32767;
                end
                default:
                begin
                    lo = -35'sd2147483648;
                    hi = 35'sd2147483647;
                end
            endcase
            if (v < lo)
                s = lo;
            else if (v > hi)
                s = hi;
            else
                s = v;
            unique case (fmt)
                FMT_S8:  r = {24'd0, s[7:0]};
                FMT_U8:  r = {24'd0, ~s[7], s[6:0]};
                FMT_S16: r = {16'd0, s[15:0]};
                default: r = s[31:0];
            endcase
            return r;
        end
    endfunction

endpackage

// ----- sv/lirs_fifo.sv -----
// Small register queue with full and empty flags.
`timescale 1ns / 1ps

module lirs_fifo
    import lirs_pkg::*;
#(
    parameter type T     = job_t,
    parameter int  DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  T     wr_data,
    output logic full,
    input  logic rd_en,
    output T     rd_data,
    output logic empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                entry_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_wr;
    logic            do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + CW'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ----- sv/lirs_front.sv -----
// Input side: decodes raw samples and tracks the channel position within a frame.
`timescale 1ns / 1ps

module lirs_front
    import lirs_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [SAMPLE_W-1:0] in_sample,
    input  logic [COUNT_W-1:0]  chan_total,
    input  fmt_t                sample_format,
    input  logic                job_full,
    output logic                job_push,
    output job_t                job_data
);

    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [CW-1:0]      pos_reg;
    logic [CW-1:0]      pos_next;
    logic [CW-1:0]      chan;
    logic [COUNT_W-1:0] cc_eff;
    logic [COUNT_W-1:0] chan_plus;
    logic               done;

    assign cc_eff    = clamp_count(chan_total, MAX_CHANNELS);
    // A position left past a lowered count restarts at channel 0.
    assign chan      = (COUNT_W'(pos_reg) >= cc_eff) ? '0 : pos_reg;
    assign chan_plus = COUNT_W'(chan) + COUNT_W'(1);
    assign done      = (chan_plus >= cc_eff);
    assign pos_next  = done ? '0 : CW'(chan_plus);
    assign job_push  = push && !job_full;

    always_comb
    begin
        job_data.chan       = CH_W'(chan);
        job_data.value      = decode_sample(in_sample, sample_format);
        job_data.frame_done = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (job_push)
            pos_reg <= pos_next;
    end

endmodule

// ----- sv/lirs_back.sv -----
// Back end: keeps the two stored frames, runs the phase loop and interpolates each channel.
`timescale 1ns / 1ps

module lirs_back
    import lirs_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int FRAC_BITS    = DEF_FRAC_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [PHASE_W-1:0] phase_step,
    input  logic [COUNT_W-1:0] chan_total,
    input  fmt_t               sample_format,
    input  logic               job_empty,
    input  job_t               job_head,
    output logic               job_pop,
    input  logic               res_full,
    output logic               res_push,
    output result_t            res_data
);

    localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PHW   = ((FRAC_BITS > PHASE_W) ? FRAC_BITS : PHASE_W) + 2;
    localparam int FL    = FRAC_BITS / 2;
    localparam int FH    = FRAC_BITS - FL;
    localparam int DW    = SAMPLE_W + 1;
    localparam int PLO_W = DW + FL + 1;
    localparam int ACC_W = DW + FRAC_BITS + 2;
    localparam int FRM_W = $clog2(FRAMES_PER_INPUT);

    localparam logic [PHW-1:0] ONE      = {{(PHW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [PHW-1:0] MIN_STEP = ONE >> 3;
    localparam logic signed [ACC_W-1:0] HALF =
        {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL_LO,
        B_MUL_HI,
        B_EMIT
    } back_state_t;

    back_state_t state_reg;
    back_state_t state_next;

    logic signed [SAMPLE_W-1:0] older_reg [MAX_CHANNELS];
    logic signed [SAMPLE_W-1:0] newer_reg [MAX_CHANNELS];

    logic [CW-1:0]     chan_reg;
    logic [CW-1:0]     chan_next;
    logic [FRM_W-1:0]  frames_reg;
    logic [FRM_W-1:0]  frames_next;
    logic [PHW-1:0]    phase_reg;
    logic [PHW-1:0]    phase_next;
    logic              first_seen_reg;
    logic              first_seen_next;

    logic signed [SAMPLE_W-1:0] s1_reg;
    logic signed [DW-1:0]       diff_reg;
    logic signed [PLO_W-1:0]    plo_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    logic [CW-1:0]              rd_idx;
    logic signed [SAMPLE_W-1:0] rd_old;
    logic signed [SAMPLE_W-1:0] rd_new;
    logic                       load_frame;

    logic [COUNT_W-1:0]         cc_eff;
    logic [PHW-1:0]             step_ext;
    logic [PHW-1:0]             step_eff;
    logic [PHW-1:0]             phase_sum;
    logic [PHW-1:0]             phase_less_one;
    logic [PHW-1:0]             phase_wrap;
    logic [PHW-1:0]             sum_less_one;
    logic [PHW-1:0]             sum_wrap;
    logic                       chan_last;
    logic                       run_last;

    logic [FRAC_BITS-1:0]       frac;
    logic signed [FL:0]         frac_lo_s;
    logic signed [FH:0]         frac_hi_s;
    logic signed [PLO_W-1:0]    plo;
    logic signed [DW+FH:0]      phi;
    logic signed [ACC_W-1:0]    acc_sum;
    logic signed [34:0]         interp_val;

    assign cc_eff    = clamp_count(chan_total, MAX_CHANNELS);
    assign step_ext  = PHW'(phase_step);
    assign step_eff  = (step_ext < MIN_STEP) ? MIN_STEP : step_ext;
    assign phase_sum = phase_reg + step_eff;

    // Leftover phase masked to PHASE_W bits, the step register width.
    assign phase_less_one = phase_reg - ONE;
    assign phase_wrap     = PHW'(phase_less_one[PHASE_W-1:0]);
    assign sum_less_one   = phase_sum - ONE;
    assign sum_wrap       = (phase_sum >= ONE) ? PHW'(sum_less_one[PHASE_W-1:0]) : '0;

    assign chan_last = ((COUNT_W'(chan_reg) + COUNT_W'(1)) == cc_eff);
    assign run_last  = (phase_sum >= ONE) || (frames_reg == FRM_W'(FRAMES_PER_INPUT - 1));

    // One shared read port on the frame store.
    assign rd_idx = (state_reg == B_IDLE) ? job_head.chan[CW-1:0] : chan_reg;
    assign rd_old = older_reg[rd_idx];
    assign rd_new = newer_reg[rd_idx];

    // Split the fraction so each product stays narrow.
    assign frac      = phase_reg[FRAC_BITS-1:0];
    assign frac_lo_s = {1'b0, frac[FL-1:0]};
    assign frac_hi_s = {1'b0, frac[FRAC_BITS-1:FL]};
    assign plo       = (DW'(rd_new) - DW'(rd_old)) * frac_lo_s;
    assign phi       = diff_reg * frac_hi_s;
    assign acc_sum   = (ACC_W'(phi) <<< FL) + ACC_W'(plo_reg) + HALF;

    // Floor shift gives round half up on the signed product.
    assign interp_val = 35'(s1_reg) + 35'(acc_reg >>> FRAC_BITS);

    always_comb
    begin
        res_data.sample = encode_sample(interp_val, sample_format);
        res_data.chan   = CH_W'(chan_reg);
        res_data.last   = chan_last && run_last;
    end

    always_comb
    begin
        state_next      = state_reg;
        chan_next       = chan_reg;
        frames_next     = frames_reg;
        phase_next      = phase_reg;
        first_seen_next = first_seen_reg;
        job_pop         = 1'b0;
        res_push        = 1'b0;
        load_frame      = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop    = 1'b1;
                    load_frame = 1'b1;
                    if (job_head.frame_done)
                    begin
                        if (!first_seen_reg)
                            first_seen_next = 1'b1;
                        else if (phase_reg < ONE)
                        begin
                            chan_next   = '0;
                            frames_next = '0;
                            state_next  = B_MUL_LO;
                        end
                        else
                            phase_next = phase_wrap;
                    end
                end
            end
            B_MUL_LO:
            begin
                state_next = B_MUL_HI;
            end
            B_MUL_HI:
            begin
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (!chan_last)
                    begin
                        chan_next  = chan_reg + CW'(1);
                        state_next = B_MUL_LO;
                    end
                    else if (run_last)
                    begin
                        phase_next = sum_wrap;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        // Advance to the next output frame.
                        chan_next   = '0;
                        frames_next = frames_reg + FRM_W'(1);
                        phase_next  = phase_sum;
                        state_next  = B_MUL_LO;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            chan_reg       <= '0;
            frames_reg     <= '0;
            phase_reg      <= '0;
            first_seen_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            chan_reg       <= chan_next;
            frames_reg     <= frames_next;
            phase_reg      <= phase_next;
            first_seen_reg <= first_seen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                older_reg[i] <= '0;
                newer_reg[i] <= '0;
            end
        end
        else if (load_frame)
        begin
            older_reg[rd_idx] <= rd_new;
            newer_reg[rd_idx] <= job_head.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_MUL_LO)
        begin
            s1_reg   <= rd_old;
            diff_reg <= DW'(rd_new) - DW'(rd_old);
            plo_reg  <= plo;
        end
        if (state_reg == B_MUL_HI)
            acc_reg <= acc_sum;
    end

endmodule

// ----- sv/linear_interp_resampler.sv -----
// Path: an input beat that completes a frame goes via the job queue to B_IDLE; each
// result beat then takes the two-step multiply (B_MUL_LO, B_MUL_HI) and output push
// (B_EMIT, held while the result queue is full). Other input beats pop in B_IDLE.
// With N channels and K output frames the back end pops no job till N*K beats are out.
// Reset: asynchronous, active low; clears both stored frames, the phase, the channel
// position and both queues, and loads the register reset values.
`timescale 1ns / 1ps

module linear_interp_resampler
    import lirs_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int FRAC_BITS    = DEF_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PHASE_W-1:0]   cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic [SAMPLE_W-1:0]  in_sample,
    output logic                 empty,
    input  logic                 pop,
    output logic [SAMPLE_W-1:0]  out_sample,
    output logic [CH_W-1:0]      out_channel,
    output logic                 last_of_run
);

    logic [PHASE_W-1:0] phase_step_reg;
    logic [COUNT_W-1:0] chan_total_reg;
    fmt_t               sample_format_reg;

    logic    job_push;
    job_t    job_in;
    logic    job_full;
    logic    job_pop;
    job_t    job_head;
    logic    job_empty;
    logic    res_push;
    result_t res_in;
    logic    res_full;
    result_t res_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg    <= PHASE_STEP_RESET;
            chan_total_reg    <= CHANNEL_COUNT_RESET;
            sample_format_reg <= FMT_S16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PHASE_STEP:    phase_step_reg    <= cfg_data;
                REG_CHANNEL_COUNT: chan_total_reg    <= cfg_data[COUNT_W-1:0];
                REG_SAMPLE_FORMAT: sample_format_reg <= fmt_t'(cfg_data[1:0]);
                default:           ;
            endcase
        end
    end

    lirs_front #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .in_sample    (in_sample),
        .chan_total   (chan_total_reg),
        .sample_format(sample_format_reg),
        .job_full     (job_full),
        .job_push     (job_push),
        .job_data     (job_in)
    );

    lirs_fifo #(
        .T    (job_t),
        .DEPTH(2)
    ) u_job_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_data(job_in),
        .full   (job_full),
        .rd_en  (job_pop),
        .rd_data(job_head),
        .empty  (job_empty)
    );

    lirs_back #(
        .MAX_CHANNELS(MAX_CHANNELS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .phase_step   (phase_step_reg),
        .chan_total   (chan_total_reg),
        .sample_format(sample_format_reg),
        .job_empty    (job_empty),
        .job_head     (job_head),
        .job_pop      (job_pop),
        .res_full     (res_full),
        .res_push     (res_push),
        .res_data     (res_in)
    );

    lirs_fifo #(
        .T    (result_t),
        .DEPTH(2)
    ) u_res_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (res_push),
        .wr_data(res_in),
        .full   (res_full),
        .rd_en  (pop),
        .rd_data(res_head),
        .empty  (empty)
    );

    assign full        = job_full;
    assign out_sample  = res_head.sample;
    assign out_channel = res_head.chan;
    assign last_of_run = res_head.last;

endmodule

// ----- sim/resample_checker.sv -----
// Checker that predicts the resampler's result beats from the input and config traffic.
`timescale 1ns / 1ps

module resample_checker
    import lirs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PHASE_W-1:0]   cfg_data,
    input  logic                 push,
    input  logic                 full,
    input  logic [SAMPLE_W-1:0]  in_sample,
    input  logic                 empty,
    input  logic                 pop,
    input  logic [SAMPLE_W-1:0]  out_sample,
    input  logic [CH_W-1:0]      out_channel,
    input  logic                 last_of_run,
    output int                   fail_count,
    output int                   pending
);

    localparam int unsigned ONE_PHASE  = 1 << DEF_FRAC_BITS;
    localparam int unsigned MIN_STEP   = ONE_PHASE >> 3;
    localparam int unsigned PHASE_MASK = (1 << PHASE_W) - 1;

    logic [PHASE_W-1:0]  step_q;
    logic [COUNT_W-1:0]  count_q;
    fmt_t                fmt_q;
    logic [SAMPLE_W-1:0] older_q [DEF_MAX_CHANNELS];
    logic [SAMPLE_W-1:0] newer_q [DEF_MAX_CHANNELS];
    int unsigned         chan_pos;
    int unsigned         phase_acc;
    bit                  primed;
    result_t             expected_beats [$];
    result_t             want;
    int                  mismatches = 0;
    int                  waiting = 0;

    assign fail_count = mismatches;
    assign pending    = waiting;

    function automatic longint decode_raw(input logic [SAMPLE_W-1:0] raw, input fmt_t fmt);
        case (fmt)
            FMT_S8:  return longint'($signed(raw[7:0]));
            FMT_U8:  return longint'(raw[7:0]) - 128;
            FMT_S16: return longint'($signed(raw[15:0]));
            default: return longint'($signed(raw));
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] encode_val(input longint v, input fmt_t fmt);
        longint lo;
        longint hi;
        longint s;
        case (fmt)
            FMT_S8, FMT_U8:
            begin
                lo = -64'sd128;
                hi = 64'sd127;
            end
            FMT_S16:
            begin
                lo = -64'sd32768;
                hi = 64'sd32767;
            end
            default:
            begin
                lo = -64'sd2147483648;
                hi = 64'sd2147483647;
            end
        endcase
        s = (v < lo) ? lo : ((v > hi) ? hi : v);
        case (fmt)
            FMT_S8:  return {24'd0, s[7:0]};
            FMT_U8:  return SAMPLE_W'(s + 128);
            FMT_S16: return {16'd0, s[15:0]};
            default: return s[31:0];
        endcase
    endfunction

    // Round half up: floor((d*frac + half) / one).
    function automatic longint blend(input longint s1, input longint s2, input int unsigned frac);
        longint p;
        p = (s2 - s1) * longint'(frac) + (longint'(1) << (DEF_FRAC_BITS - 1));
        return s1 + (p >>> DEF_FRAC_BITS);
    endfunction

    task automatic resample_beat(input logic [SAMPLE_W-1:0] raw);
        int unsigned cc;
        int unsigned ch;
        int unsigned stp;
        int unsigned frames;
        int          n0;
        result_t     r;
        cc = count_q;
        if (cc < 1)
            cc = 1;
        if (cc > DEF_MAX_CHANNELS)
            cc = DEF_MAX_CHANNELS;
        ch = (chan_pos >= cc) ? 0 : chan_pos;
        older_q[ch] = newer_q[ch];
        newer_q[ch] = SAMPLE_W'(decode_raw(raw, fmt_q));
        if (ch + 1 < cc)
        begin
            chan_pos = ch + 1;
            return;
        end
        chan_pos = 0;
        // need two frames before anything can be interpolated
        if (!primed)
        begin
            primed = 1'b1;
            return;
        end
        stp = (step_q < MIN_STEP) ? MIN_STEP : step_q;
        frames = 0;
        n0 = expected_beats.size();
        while (phase_acc < ONE_PHASE && frames < FRAMES_PER_INPUT)
        begin
            for (int unsigned c = 0; c < cc; c++)
            begin
                r.sample = encode_val(blend(longint'($signed(older_q[c])),
                                            longint'($signed(newer_q[c])), phase_acc), fmt_q);
                r.chan = CH_W'(c);
                r.last = 1'b0;
                expected_beats.push_back(r);
            end
            phase_acc += stp;
            frames++;
        end
        phase_acc = (phase_acc >= ONE_PHASE) ? phase_acc - ONE_PHASE : 0;
        phase_acc &= PHASE_MASK;
        if (expected_beats.size() > n0)
            expected_beats[expected_beats.size() - 1].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_q = PHASE_STEP_RESET;
            count_q = CHANNEL_COUNT_RESET;
            fmt_q = FMT_S16;
            for (int i = 0; i < DEF_MAX_CHANNELS; i++)
            begin
                older_q[i] = '0;
                newer_q[i] = '0;
            end
            chan_pos = 0;
            phase_acc = 0;
            primed = 1'b0;
            expected_beats.delete();
            waiting <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PHASE_STEP:    step_q = cfg_data;
                    REG_CHANNEL_COUNT: count_q = cfg_data[COUNT_W-1:0];
                    REG_SAMPLE_FORMAT: fmt_q = fmt_t'(cfg_data[1:0]);
                    default: ;
                endcase
            end
            if (pop && !empty)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("unexpected result beat: out_sample %h out_channel %0d last_of_run %b",
                           out_sample, out_channel, last_of_run);
                    mismatches++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (out_sample !== want.sample)
                    begin
                        $error("out_sample: expected %h, got %h", want.sample, out_sample);
                        mismatches++;
                    end
                    if (out_channel !== want.chan)
                    begin
                        $error("out_channel: expected %0d, got %0d", want.chan, out_channel);
                        mismatches++;
                    end
                    if (last_of_run !== want.last)
                    begin
                        $error("last_of_run: expected %b, got %b", want.last, last_of_run);
                        mismatches++;
                    end
                end
            end
            if (push && !full)
                resample_beat(in_sample);
            waiting <= expected_beats.size();
        end
    end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the linear interpolation resampler: stimulus, config phases and verdict.
`timescale 1ns / 1ps

module tb_top;
    import lirs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 32;
    localparam int SINK_HOLD     = 600;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_PHASE_STEP;
    logic [PHASE_W-1:0]   cfg_data = '0;
    logic                 push = 1'b0;
    logic                 full;
    logic [SAMPLE_W-1:0]  in_sample = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [SAMPLE_W-1:0]  out_sample;
    logic [CH_W-1:0]      out_channel;
    logic                 last_of_run;
    int                   fail_count;
    int                   pending;
    bit                   src_quiet = 1'b0;
    bit                   hold_sink = 1'b0;

    linear_interp_resampler dut (.*);

    resample_checker chk (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int idle_len(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] r;
        r = $urandom();
        case ($urandom_range(0, 11))
            0: r = '0;
            1: r = '1;
            2: r = 32'h7FFF_FFFF;
            3: r = 32'h8000_0000;
            4: r[15:0] = 16'h7FFF;
            5: r[15:0] = 16'h8000;
            6: r[7:0] = 8'h7F;
            7: r[7:0] = 8'h80;
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [PHASE_W-1:0] pick_step();
        case ($urandom_range(0, 9))
            0: return PHASE_W'($urandom_range(0, 8191));
            1: return PHASE_W'($urandom_range(131072, 1048576));
            2: return PHASE_W'(8192);
            3: return '1;
            default: return PHASE_W'($urandom_range(8192, 131072));
        endcase
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return COUNT_W'($urandom_range(1, 3));
        if (r < 8)
            return COUNT_W'($urandom_range(4, 8));
        if (r < 9)
            return '0;
        return COUNT_W'($urandom_range(9, 15));
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PHASE_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_beat(input logic [SAMPLE_W-1:0] v);
        int g;
        g = idle_len(src_quiet);
        if (g > 0)
        begin
            push <= 1'b0;
            repeat (g) @(posedge clk);
        end
        push <= 1'b1;
        in_sample <= v;
        do @(posedge clk); while (full);
    endtask

    // Drop push, drain every expected beat, then let the block finish frameless beats.
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: first frame yields nothing, then outputs sit at frame 0
        write_reg(REG_UNUSED, PHASE_W'($urandom()));
        send_beat(32'hABCD_7FFF);
        send_beat(32'h1234_8000);
        send_beat(32'hFFFF_8000);
        send_beat(32'h0000_7FFF);
        settle();

        // step 0 is raised to 1/8, count 0 acts as one channel; covers the rounding ties
        write_reg(REG_PHASE_STEP, '0);
        write_reg(REG_CHANNEL_COUNT, {17'h1ABCD, 4'd0});
        write_reg(REG_SAMPLE_FORMAT, {19'h5A5A5, FMT_S8});
        send_beat(32'hFFFF_FF00);
        send_beat(32'h0000_0001);
        send_beat(32'h0000_0000);
        send_beat(32'h0000_00FF);
        send_beat(32'h1234_5680);
        send_beat(32'h0000_007F);
        settle();

        write_reg(REG_PHASE_STEP, '1);
        write_reg(REG_CHANNEL_COUNT, PHASE_W'(2));
        write_reg(REG_SAMPLE_FORMAT, PHASE_W'(FMT_S32));
        send_beat(32'h7FFF_FFFF);
        send_beat(32'h8000_0000);
        send_beat(32'h8000_0000);
        send_beat(32'h7FFF_FFFF);
        settle();

        // leave a three-channel frame one beat in, then shrink the count under it and switch format
        write_reg(REG_PHASE_STEP, PHASE_W'(8192));
        write_reg(REG_CHANNEL_COUNT, PHASE_W'(3));
        write_reg(REG_SAMPLE_FORMAT, PHASE_W'(FMT_S16));
        send_beat(32'h0000_8000);
        settle();
        write_reg(REG_CHANNEL_COUNT, PHASE_W'(1));
        write_reg(REG_SAMPLE_FORMAT, PHASE_W'(FMT_U8));
        send_beat(32'hFFFF_FF00);
        send_beat(32'h0000_00FF);
        send_beat(32'h0000_0080);
        settle();

        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph == 0)
            begin
                write_reg(REG_PHASE_STEP, PHASE_W'(1048576));
                write_reg(REG_CHANNEL_COUNT, PHASE_W'(15));
                n = 24;
            end
            else if (ph == 3)
            begin
                // back the sink off while the source streams at full rate
                write_reg(REG_PHASE_STEP, PHASE_W'(8192));
                write_reg(REG_CHANNEL_COUNT, PHASE_W'(1));
                n = 50;
            end
            else
            begin
                write_reg(REG_PHASE_STEP, pick_step());
                write_reg(REG_CHANNEL_COUNT, PHASE_W'({17'($urandom()), pick_count()}));
                n = $urandom_range(18, 28);
            end
            write_reg(REG_SAMPLE_FORMAT, PHASE_W'({19'($urandom()), 2'($urandom_range(0, 3))}));
            src_quiet = (ph == 3) || ($urandom_range(0, 3) == 0);
            hold_sink = (ph == 3);
            for (int i = 0; i < n; i++)
                send_beat(pick_sample());
            settle();
        end

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int  g;
        int  taken;
        bit  quiet;
        bit  held;
        taken = 0;
        quiet = 1'b0;
        held = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_sink && !held)
            begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (SINK_HOLD) @(posedge clk);
            end
            g = idle_len(quiet);
            if (g > 0)
            begin
                pop <= 1'b0;
                repeat (g) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            taken++;
            if (taken % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
        end
    end

endmodule
